>>> hw/rtl/pjqs_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the print job queue scheduler.
package pjqs_pkg;

	// Request codes carried by req_type
	typedef enum logic [2:0] {
		REQ_ENQ    = 3'd0,
		REQ_DEQ    = 3'd1,
		REQ_PEEK   = 3'd2,
		REQ_CANCEL = 3'd3,
		REQ_TICK   = 3'd4
	} req_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ALREADY   = 3'd4,
		ST_DROPPED   = 3'd5
	} st_t;

	// Job states kept per queue entry
	typedef enum logic [1:0] {
		JS_QUEUED    = 2'd0,
		JS_PRINTING  = 2'd1,
		JS_COMPLETED = 2'd2,
		JS_CANCELLED = 2'd3
	} js_t;

	// One queue entry as stored in the job memory
	typedef struct packed {
		logic [15:0] id;
		logic [11:0] pages;
		logic [7:0]  copies;
		js_t         state;
	} entry_t;

	// Controller states
	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_HEAD,
		FSM_SCAN,
		FSM_PUSH
	} fsm_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_ENQ,
		OP_FULL,
		OP_EMPTY,
		OP_MISS,
		OP_IGNORE,
		OP_HEAD,
		OP_SCAN_START,
		OP_SCAN,
		OP_PUSH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       empty;
		logic       full;
		logic       scan_hit;
		logic       scan_end;
		logic       out_free;
	} sts_t;

endpackage

>>> hw/rtl/pjqs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pjqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/pjqs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences each request through the datapath.
module pjqs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  pjqs_pkg::sts_t  sts,
	output pjqs_pkg::cmd_t  cmd
);

	pjqs_pkg::fsm_t state_q;
	pjqs_pkg::fsm_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pjqs_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd.op   = pjqs_pkg::OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			pjqs_pkg::FSM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = pjqs_pkg::OP_CAPTURE;
					state_d = pjqs_pkg::FSM_DECODE;
				end
			end
			pjqs_pkg::FSM_DECODE: begin
				state_d = pjqs_pkg::FSM_PUSH;
				unique case (sts.req)
					pjqs_pkg::REQ_ENQ: begin
						cmd.op = sts.full ? pjqs_pkg::OP_FULL : pjqs_pkg::OP_ENQ;
					end
					pjqs_pkg::REQ_DEQ, pjqs_pkg::REQ_PEEK, pjqs_pkg::REQ_TICK: begin
						// head read is issued this cycle
						if (sts.empty) begin
							cmd.op = pjqs_pkg::OP_EMPTY;
						end else begin
							state_d = pjqs_pkg::FSM_HEAD;
						end
					end
					pjqs_pkg::REQ_CANCEL: begin
						if (sts.empty) begin
							cmd.op = pjqs_pkg::OP_MISS;
						end else begin
							cmd.op  = pjqs_pkg::OP_SCAN_START;
							state_d = pjqs_pkg::FSM_SCAN;
						end
					end
					default: begin
						cmd.op = pjqs_pkg::OP_IGNORE;
					end
				endcase
			end
			pjqs_pkg::FSM_HEAD: begin
				cmd.op  = pjqs_pkg::OP_HEAD;
				state_d = pjqs_pkg::FSM_PUSH;
			end
			pjqs_pkg::FSM_SCAN: begin
				cmd.op = pjqs_pkg::OP_SCAN;
				if (sts.scan_hit || sts.scan_end) begin
					state_d = pjqs_pkg::FSM_PUSH;
				end
			end
			pjqs_pkg::FSM_PUSH: begin
				// hold the result until the output register frees up
				if (sts.out_free) begin
					cmd.op  = pjqs_pkg::OP_PUSH;
					state_d = pjqs_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = pjqs_pkg::FSM_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/pjqs_dp.sv
`timescale 1ns / 1ps
// Datapath: job memory, ring pointers, print counters, scan pipeline and output register.
module pjqs_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pjqs_pkg::cmd_t cmd,
	output pjqs_pkg::sts_t sts,
	input  logic [2:0]     req_type,
	input  logic [11:0]    page_count,
	input  logic [7:0]     copy_count,
	input  logic [15:0]    target_id,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     status,
	output logic [15:0]    job_id,
	output logic [11:0]    job_pages,
	output logic [7:0]     job_copies,
	output logic [1:0]     job_status,
	output logic           page_printed,
	output logic           job_done,
	output logic [31:0]    completed_total,
	output logic [31:0]    pages_total
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = $bits(pjqs_pkg::entry_t);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [OW-1:0] FULL_OCC = OW'(QUEUE_DEPTH);

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	// Control state
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [OW-1:0] occ_q;
	logic [15:0]   next_id_q;
	logic [7:0]    copy_idx_q;
	logic [11:0]   pages_left_q;
	logic [31:0]   done_q;
	logic [31:0]   printed_q;
	logic [PW-1:0] iss_ptr_q;
	logic [OW-1:0] iss_cnt_q;
	logic [OW-1:0] cmp_cnt_q;
	logic          rv_s1;
	logic          out_valid_q;

	// Payload registers
	logic [2:0]          req_q;
	logic [11:0]         page_q;
	logic [7:0]          copies_q;
	logic [15:0]         target_q;
	logic [PW-1:0]       rp_s1;
	pjqs_pkg::st_t       res_status_q;
	pjqs_pkg::entry_t    res_entry_q;
	logic                res_page_q;
	logic                res_done_q;
	logic [2:0]          out_status_q;
	pjqs_pkg::entry_t    out_entry_q;
	logic                out_page_q;
	logic                out_done_q;
	logic [31:0]         out_done_cnt_q;
	logic [31:0]         out_page_cnt_q;

	// Memory port signals
	logic             ram_we;
	logic [PW-1:0]    ram_waddr;
	pjqs_pkg::entry_t ram_wdata;
	logic [PW-1:0]    ram_raddr;
	logic [EW-1:0]    ram_rdata;
	pjqs_pkg::entry_t e;

	// Tick arithmetic
	logic        fresh;
	logic [11:0] pl0;
	logic [11:0] pl1;
	logic [11:0] pl2;
	logic [7:0]  ci0;
	logic [7:0]  ci1;
	logic        finish;

	// Scan compare
	logic hit;
	logic scan_end;

	// Result and update controls
	logic             res_ld;
	pjqs_pkg::st_t    res_status;
	pjqs_pkg::entry_t res_entry;
	logic             res_page;
	logic             res_done;
	logic             do_push;
	logic             do_pop;
	logic             do_fin;
	logic             do_page;

	assign e = pjqs_pkg::entry_t'(ram_rdata);

	// Read the scan pointer while searching, the head otherwise
	assign ram_raddr = (cmd.op == pjqs_pkg::OP_SCAN) ? iss_ptr_q : head_q;

	pjqs_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Work out one print tick on the head entry
	always_comb begin
		fresh  = (e.state != pjqs_pkg::JS_PRINTING);
		pl0    = fresh ? e.pages : pages_left_q;
		ci0    = fresh ? ((e.pages == 12'd0) ? e.copies : 8'd0) : copy_idx_q;
		finish = (ci0 >= e.copies);
		pl1    = (pl0 != 12'd0) ? pl0 - 12'd1 : pl0;
		ci1    = ci0;
		pl2    = pl1;
		if (pl1 == 12'd0) begin
			ci1 = ci0 + 8'd1;
			if (ci1 < e.copies) begin
				pl2 = e.pages;
			end
		end
	end

	// Compare the entry returned by the scan read
	assign hit      = rv_s1 && (e.id == target_q);
	assign scan_end = rv_s1 && !hit && ((cmp_cnt_q + 1'b1) == occ_q);

	// Decode the command into memory writes, results and updates
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = tail_q;
		ram_wdata  = '{id: next_id_q, pages: page_q, copies: copies_q,
			state: pjqs_pkg::JS_QUEUED};
		res_ld     = 1'b0;
		res_status = pjqs_pkg::ST_OK;
		res_entry  = '0;
		res_page   = 1'b0;
		res_done   = 1'b0;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_fin     = 1'b0;
		do_page    = 1'b0;
		unique case (cmd.op)
			pjqs_pkg::OP_ENQ: begin
				ram_we    = 1'b1;
				res_ld    = 1'b1;
				res_entry = ram_wdata;
				do_push   = 1'b1;
			end
			pjqs_pkg::OP_FULL: begin
				res_ld     = 1'b1;
				res_status = pjqs_pkg::ST_FULL;
			end
			pjqs_pkg::OP_EMPTY: begin
				res_ld     = 1'b1;
				res_status = pjqs_pkg::ST_EMPTY;
			end
			pjqs_pkg::OP_MISS: begin
				res_ld     = 1'b1;
				res_status = pjqs_pkg::ST_NOT_FOUND;
			end
			pjqs_pkg::OP_IGNORE: begin
				res_ld = 1'b1;
			end
			pjqs_pkg::OP_HEAD: begin
				res_ld    = 1'b1;
				res_entry = e;
				if (req_q == pjqs_pkg::REQ_DEQ) begin
					do_pop = 1'b1;
				end else if (req_q == pjqs_pkg::REQ_TICK) begin
					if (e.state == pjqs_pkg::JS_CANCELLED) begin
						res_status = pjqs_pkg::ST_DROPPED;
						do_pop     = 1'b1;
					end else begin
						ram_we          = 1'b1;
						ram_waddr       = head_q;
						ram_wdata       = e;
						ram_wdata.state = finish ? pjqs_pkg::JS_COMPLETED
							: pjqs_pkg::JS_PRINTING;
						res_entry       = ram_wdata;
						res_done        = finish;
						res_page        = !finish;
						do_pop          = finish;
						do_fin          = finish;
						do_page         = !finish;
					end
				end
			end
			pjqs_pkg::OP_SCAN: begin
				if (hit) begin
					res_ld    = 1'b1;
					res_entry = e;
					if (e.state == pjqs_pkg::JS_COMPLETED) begin
						res_status = pjqs_pkg::ST_ALREADY;
					end else begin
						ram_we          = 1'b1;
						ram_waddr       = rp_s1;
						ram_wdata       = e;
						ram_wdata.state = pjqs_pkg::JS_CANCELLED;
						res_entry       = ram_wdata;
					end
				end else if (scan_end) begin
					res_ld     = 1'b1;
					res_status = pjqs_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			occ_q        <= '0;
			next_id_q    <= 16'd1;
			copy_idx_q   <= '0;
			pages_left_q <= '0;
			done_q       <= '0;
			printed_q    <= '0;
			iss_ptr_q    <= '0;
			iss_cnt_q    <= '0;
			cmp_cnt_q    <= '0;
			rv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// advance the tail on enqueue
			if (do_push) begin
				tail_q    <= ring_next(tail_q);
				next_id_q <= next_id_q + 16'd1;
				occ_q     <= occ_q + 1'b1;
			end
			// drop the head
			if (do_pop) begin
				head_q <= ring_next(head_q);
				occ_q  <= occ_q - 1'b1;
			end
			if (do_fin) begin
				pages_left_q <= pl0;
				copy_idx_q   <= ci0;
				done_q       <= done_q + 32'd1;
			end
			if (do_page) begin
				pages_left_q <= pl2;
				copy_idx_q   <= ci1;
				printed_q    <= printed_q + 32'd1;
			end
			// scan pipeline: issue one read a cycle, count compares
			if (cmd.op == pjqs_pkg::OP_SCAN_START) begin
				iss_ptr_q <= head_q;
				iss_cnt_q <= '0;
				cmp_cnt_q <= '0;
				rv_s1     <= 1'b0;
			end else if (cmd.op == pjqs_pkg::OP_SCAN) begin
				if (iss_cnt_q < occ_q) begin
					rv_s1     <= 1'b1;
					iss_ptr_q <= ring_next(iss_ptr_q);
					iss_cnt_q <= iss_cnt_q + 1'b1;
				end else begin
					rv_s1 <= 1'b0;
				end
				if (rv_s1) begin
					cmp_cnt_q <= cmp_cnt_q + 1'b1;
				end
			end
			// output register valid
			if (cmd.op == pjqs_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == pjqs_pkg::OP_CAPTURE) begin
			req_q    <= req_type;
			page_q   <= page_count;
			copies_q <= copy_count;
			target_q <= target_id;
		end
		rp_s1 <= iss_ptr_q;
		if (res_ld) begin
			res_status_q <= res_status;
			res_entry_q  <= res_entry;
			res_page_q   <= res_page;
			res_done_q   <= res_done;
		end
		if (cmd.op == pjqs_pkg::OP_PUSH) begin
			out_status_q   <= res_status_q;
			out_entry_q    <= res_entry_q;
			out_page_q     <= res_page_q;
			out_done_q     <= res_done_q;
			out_done_cnt_q <= done_q;
			out_page_cnt_q <= printed_q;
		end
	end

	// Status to the controller
	always_comb begin
		sts.req      = req_q;
		sts.empty    = (occ_q == '0);
		sts.full     = (occ_q == FULL_OCC);
		sts.scan_hit = hit;
		sts.scan_end = scan_end;
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign job_id          = out_entry_q.id;
	assign job_pages       = out_entry_q.pages;
	assign job_copies      = out_entry_q.copies;
	assign job_status      = out_entry_q.state;
	assign page_printed    = out_page_q;
	assign job_done        = out_done_q;
	assign completed_total = out_done_cnt_q;
	assign pages_total     = out_page_cnt_q;

endmodule

>>> hw/rtl/print_job_queue_scheduler.sv
`timescale 1ns / 1ps
// Print job queue scheduler: a ring of QUEUE_DEPTH jobs kept in one job memory, served one
// request at a time. Enqueue, full and empty answers and unknown requests pass through the
// decode and push states; dequeue, peek and print tick also pass through the head state, since
// the head entry is read from the memory first. Cancel by id reads one entry per cycle from the
// head through the single memory read port, until the id is found or every occupied entry has
// been compared. A result waits in an output register, so the next item is taken while it is
// still held; a further result waits until the output register is free. The job memory is not
// cleared after reset; only occupied entries are ever used in a result.
module print_job_queue_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [11:0] page_count,
	input  logic [7:0]  copy_count,
	input  logic [15:0] target_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] job_id,
	output logic [11:0] job_pages,
	output logic [7:0]  job_copies,
	output logic [1:0]  job_status,
	output logic        page_printed,
	output logic        job_done,
	output logic [31:0] completed_total,
	output logic [31:0] pages_total
);

	pjqs_pkg::cmd_t cmd;
	pjqs_pkg::sts_t sts;

	// Sequence each request
	pjqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Queue storage and counters
	pjqs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req_type),
		.page_count      (page_count),
		.copy_count      (copy_count),
		.target_id       (target_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.job_id          (job_id),
		.job_pages       (job_pages),
		.job_copies      (job_copies),
		.job_status      (job_status),
		.page_printed    (page_printed),
		.job_done        (job_done),
		.completed_total (completed_total),
		.pages_total     (pages_total)
	);

endmodule

>>> hw/rtl/pjqs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the print job queue scheduler and its bind.
module pjqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] job_id,
	input logic [1:0]  job_status,
	input logic        page_printed,
	input logic        job_done
);

	// Hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(job_id))
		else $error("stalled item changed");

	// A completion carries an ok status and a completed job
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && job_done |-> status == pjqs_pkg::ST_OK
			&& job_status == pjqs_pkg::JS_COMPLETED && !page_printed)
		else $error("completion item inconsistent");

	// A printed page comes from a printing job
	a_page_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && page_printed |-> status == pjqs_pkg::ST_OK
			&& job_status == pjqs_pkg::JS_PRINTING)
		else $error("page item inconsistent");

	// Refusals name no job
	a_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == pjqs_pkg::ST_EMPTY || status == pjqs_pkg::ST_FULL
			|| status == pjqs_pkg::ST_NOT_FOUND)
		|-> job_id == 16'd0 && !page_printed && !job_done)
		else $error("refusal carries job data");

endmodule

bind print_job_queue_scheduler pjqs_checker u_pjqs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.job_id       (job_id),
	.job_status   (job_status),
	.page_printed (page_printed),
	.job_done     (job_done)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the print job queue scheduler: directed cases, then random traffic.
module tb;

	localparam int QDEPTH      = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_JOBS = 1700;
	// Request codes the block does not know; it must answer them with zeros apart from the running totals
	localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

	typedef enum {ROUND_FILL, ROUND_DRAIN, ROUND_MIXED} round_kind_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_kind_t;

	// One answer of the block, field by field
	typedef struct packed {
		pjqs_pkg::st_t st;
		logic [15:0]   id;
		logic [11:0]   pages;
		logic [7:0]    copies;
		pjqs_pkg::js_t js;
		logic          printed;
		logic          done;
		logic [31:0]   completed;
		logic [31:0]   page_tot;
	} job_answer_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic [2:0]  req_type     = '0;
	logic [11:0] page_count   = '0;
	logic [7:0]  copy_count   = '0;
	logic [15:0] target_id    = '0;
	logic        out_stall    = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  status;
	logic [15:0] job_id;
	logic [11:0] job_pages;
	logic [7:0]  job_copies;
	logic [1:0]  job_status;
	logic        page_printed;
	logic        job_done;
	logic [31:0] completed_total;
	logic [31:0] pages_total;

	// Queue model: ring of jobs plus the print cursor and running totals
	pjqs_pkg::entry_t job_ring [QDEPTH];
	int               ring_head, ring_tail, ring_fill;
	logic [15:0]      id_counter;
	logic [7:0]       copy_at;
	logic [11:0]      pages_left_m;
	logic [31:0]      jobs_done_total, pages_done_total;
	job_answer_t      answer_q [$];

	int          requests_sent, results_checked, mismatch_count, quiet_cycles;
	int          full_seen, empties_seen, drops_seen, cancel_hits;
	int          burst_left, stall_phase;
	bit          sender_idles;
	stall_kind_t stall_mode;

	print_job_queue_scheduler #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.page_count(page_count),
		.copy_count(copy_count),
		.target_id(target_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.job_id(job_id),
		.job_pages(job_pages),
		.job_copies(job_copies),
		.job_status(job_status),
		.page_printed(page_printed),
		.job_done(job_done),
		.completed_total(completed_total),
		.pages_total(pages_total)
	);

	always #5 clk = ~clk;

	// Drive receiver backpressure on its own pattern
	always @(negedge clk) begin
		stall_phase++;
		case (stall_mode)
			STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < 35);
			STALL_PERIODIC: out_stall = ((stall_phase % 5) < 2);
			STALL_LONG:     out_stall = ((stall_phase % 23) < 9);
			default:        out_stall = 1'b0;
		endcase
	end

	// Watch for a stuck handshake on both channels
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] MISMATCH %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				results_checked, name, got, want));
	endtask

	task automatic compare_answer(input job_answer_t got);
		job_answer_t want;
		if (answer_q.size() == 0) begin
			flag_mismatch($sformatf("result with no request pending: status %0d id %0d",
				got.st, got.id));
			return;
		end
		want = answer_q.pop_front();
		check_field("status", got.st, want.st);
		check_field("job_id", got.id, want.id);
		check_field("job_pages", got.pages, want.pages);
		check_field("job_copies", got.copies, want.copies);
		check_field("job_status", got.js, want.js);
		check_field("page_printed", got.printed, want.printed);
		check_field("job_done", got.done, want.done);
		check_field("completed_total", got.completed, want.completed);
		check_field("pages_total", got.page_tot, want.page_tot);
		results_checked++;
	endtask

	// Check every result taken from the block
	always @(posedge clk) begin
		job_answer_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.st        = pjqs_pkg::st_t'(status);
			got.id        = job_id;
			got.pages     = job_pages;
			got.copies    = job_copies;
			got.js        = pjqs_pkg::js_t'(job_status);
			got.printed   = page_printed;
			got.done      = job_done;
			got.completed = completed_total;
			got.page_tot  = pages_total;
			compare_answer(got);
		end
	end

	function automatic job_answer_t show_slot(input job_answer_t a, input int slot);
		a.id     = job_ring[slot].id;
		a.pages  = job_ring[slot].pages;
		a.copies = job_ring[slot].copies;
		a.js     = job_ring[slot].state;
		return a;
	endfunction

	function automatic void pop_head();
		ring_head = (ring_head + 1) % QDEPTH;
		ring_fill--;
	endfunction

	// Work out the answer to one accepted request and queue it
	task automatic predict_request(input logic [2:0] req, input logic [11:0] pages,
			input logic [7:0] copies, input logic [15:0] target);
		job_answer_t ans;
		int          slot;
		bit          hit;
		ans  = '0;
		slot = ring_head;
		hit  = 1'b0;
		case (req)
			pjqs_pkg::REQ_ENQ: begin
				if (ring_fill >= QDEPTH) begin
					ans.st = pjqs_pkg::ST_FULL;
					full_seen++;
				end else begin
					job_ring[ring_tail] = '{id: id_counter, pages: pages, copies: copies,
						state: pjqs_pkg::JS_QUEUED};
					ans = show_slot(ans, ring_tail);
					id_counter++;
					ring_tail = (ring_tail + 1) % QDEPTH;
					ring_fill++;
				end
			end
			pjqs_pkg::REQ_DEQ, pjqs_pkg::REQ_PEEK: begin
				if (ring_fill == 0) begin
					ans.st = pjqs_pkg::ST_EMPTY;
					empties_seen++;
				end else begin
					ans = show_slot(ans, ring_head);
					if (req == pjqs_pkg::REQ_DEQ)
						pop_head();
				end
			end
			pjqs_pkg::REQ_CANCEL: begin
				// search from the head; first match wins
				for (int k = 0; k < ring_fill && !hit; k++) begin
					if (job_ring[slot].id == target) begin
						hit = 1'b1;
						if (job_ring[slot].state == pjqs_pkg::JS_COMPLETED) begin
							ans.st = pjqs_pkg::ST_ALREADY;
						end else begin
							job_ring[slot].state = pjqs_pkg::JS_CANCELLED;
							cancel_hits++;
						end
						ans = show_slot(ans, slot);
					end else begin
						slot = (slot + 1) % QDEPTH;
					end
				end
				if (!hit)
					ans.st = pjqs_pkg::ST_NOT_FOUND;
			end
			pjqs_pkg::REQ_TICK: begin
				if (ring_fill == 0) begin
					ans.st = pjqs_pkg::ST_EMPTY;
					empties_seen++;
				end else if (job_ring[slot].state == pjqs_pkg::JS_CANCELLED) begin
					ans    = show_slot(ans, slot);
					ans.st = pjqs_pkg::ST_DROPPED;
					drops_seen++;
					pop_head();
				end else begin
					// load the print cursor when the head starts printing
					if (job_ring[slot].state != pjqs_pkg::JS_PRINTING) begin
						job_ring[slot].state = pjqs_pkg::JS_PRINTING;
						pages_left_m = job_ring[slot].pages;
						copy_at = (job_ring[slot].pages == 0) ? job_ring[slot].copies : 8'd0;
					end
					if (copy_at >= job_ring[slot].copies) begin
						job_ring[slot].state = pjqs_pkg::JS_COMPLETED;
						jobs_done_total++;
						ans      = show_slot(ans, slot);
						ans.done = 1'b1;
						pop_head();
					end else begin
						if (pages_left_m > 0)
							pages_left_m--;
						pages_done_total++;
						ans.printed = 1'b1;
						// advance to the next copy after its last page
						if (pages_left_m == 0) begin
							copy_at++;
							if (copy_at < job_ring[slot].copies)
								pages_left_m = job_ring[slot].pages;
						end
						ans = show_slot(ans, slot);
					end
				end
			end
			default: ;
		endcase
		ans.completed = jobs_done_total;
		ans.page_tot  = pages_done_total;
		answer_q.push_back(ans);
	endtask

	// Present one item, hold it until taken, then predict its answer
	task automatic send_request(input logic [2:0] req, input logic [11:0] pages,
			input logic [7:0] copies, input logic [15:0] target);
		if (sender_idles && burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid   = 1'b1;
		req_type   = req;
		page_count = pages;
		copy_count = copies;
		target_id  = target;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_request(req, pages, copies, target);
		requests_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic post_job(input logic [11:0] pages, input logic [7:0] copies);
		send_request(pjqs_pkg::REQ_ENQ, pages, copies, 16'($urandom));
	endtask

	task automatic post_cancel(input logic [15:0] target);
		send_request(pjqs_pkg::REQ_CANCEL, 12'($urandom), 8'($urandom), target);
	endtask

	task automatic post_plain(input logic [2:0] req);
		send_request(req, 12'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// Hold the sender until every pending answer has come back
	task automatic wait_for_results();
		in_valid = 1'b0;
		while (answer_q.size() != 0)
			@(negedge clk);
	endtask

	// Mostly live ids, some just retired, some anywhere in the id space
	function automatic logic [15:0] pick_cancel_target();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65 && ring_fill > 0)
			return job_ring[(ring_head + $urandom_range(0, ring_fill - 1)) % QDEPTH].id;
		if (roll < 80)
			return id_counter - 16'(ring_fill) - 16'($urandom_range(1, 4));
		return 16'($urandom);
	endfunction

	task automatic test_empty_queue();
		post_plain(pjqs_pkg::REQ_DEQ);
		post_plain(pjqs_pkg::REQ_PEEK);
		post_plain(pjqs_pkg::REQ_TICK);
		post_cancel(16'h0000);
		post_plain(REQ_LAST_UNUSED);
	endtask

	task automatic test_job_printing();
		// one page twice, then a job with no pages and one with no copies
		post_job(12'd1, 8'd2);
		post_job(12'd0, 8'd3);
		post_job(12'd3, 8'd0);
		repeat (5) post_plain(pjqs_pkg::REQ_TICK);
	endtask

	task automatic test_cancel_and_dequeue();
		logic [15:0] big_id;
		big_id = id_counter;
		post_job(12'hFFF, 8'hFF);
		post_plain(pjqs_pkg::REQ_TICK);
		// cancel the printing head twice, then let a tick drop it
		post_cancel(big_id);
		post_cancel(big_id);
		post_plain(pjqs_pkg::REQ_TICK);
		post_cancel(16'hFFFF);
		// remove a head in the middle of printing
		post_job(12'hFFF, 8'd1);
		post_plain(pjqs_pkg::REQ_TICK);
		post_plain(pjqs_pkg::REQ_DEQ);
		post_plain(pjqs_pkg::REQ_PEEK);
	endtask

	task automatic post_random_job();
		if ($urandom_range(0, 99) < 6)
			post_job(12'($urandom), 8'($urandom));
		else
			post_job(12'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
	endtask

	task automatic test_random_traffic(input int job_goal);
		int          counted, roll;
		int          enq_cut, tick_cut, cancel_cut, deq_cut, peek_cut;
		round_kind_t kind;
		counted = 0;
		while (counted < job_goal) begin
			kind         = round_kind_t'($urandom_range(0, 2));
			stall_mode   = stall_kind_t'($urandom_range(0, 3));
			sender_idles = ($urandom_range(0, 3) != 0);
			case (kind)
				ROUND_FILL: begin
					enq_cut = 55; tick_cut = 70; cancel_cut = 82; deq_cut = 88; peek_cut = 95;
				end
				ROUND_DRAIN: begin
					enq_cut = 8; tick_cut = 70; cancel_cut = 82; deq_cut = 90; peek_cut = 96;
				end
				default: begin
					enq_cut = 30; tick_cut = 65; cancel_cut = 80; deq_cut = 88; peek_cut = 95;
				end
			endcase
			repeat ($urandom_range(15, 60)) begin
				roll = $urandom_range(0, 99);
				if (roll < enq_cut)
					post_random_job();
				else if (roll < tick_cut)
					post_plain(pjqs_pkg::REQ_TICK);
				else if (roll < cancel_cut)
					post_cancel(pick_cancel_target());
				else if (roll < deq_cut)
					post_plain(pjqs_pkg::REQ_DEQ);
				else if (roll < peek_cut)
					post_plain(pjqs_pkg::REQ_PEEK);
				else
					post_plain(3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED)));
				if (roll < peek_cut)
					counted++;
			end
			if ($urandom_range(0, 3) == 0)
				wait_for_results();
		end
	endtask

	initial begin
		ring_head    = 0;
		ring_tail    = 0;
		ring_fill    = 0;
		id_counter   = 16'd1;
		copy_at      = '0;
		pages_left_m = '0;
		jobs_done_total  = '0;
		pages_done_total = '0;
		sender_idles = 1'b1;
		stall_mode   = STALL_RANDOM;
		burst_left   = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_job_printing();
		test_cancel_and_dequeue();
		wait_for_results();
		test_random_traffic(RANDOM_JOBS);

		// let any stray result show up before closing
		wait_for_results();
		repeat (40) @(negedge clk);
		$display("Ran %0d requests, checked %0d results: %0d full, %0d empty, %0d cancels,",
			requests_sent, results_checked, full_seen, empties_seen, cancel_hits);
		$display("%0d heads dropped, %0d jobs completed, %0d pages printed, %0d mismatches",
			drops_seen, jobs_done_total, pages_done_total, mismatch_count);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
